FILE: rtl/core/ffd_pkg.sv
// Package for the form field extractor: payload types, register indexes,
// character codes and sizing defaults. No dependencies.
`default_nettype none

package ffd_pkg;

	// Sizing defaults for the top-level parameters
	localparam int unsigned MAX_KEY_CHARS_DEF   = 16;
	localparam int unsigned MAX_VALUE_BYTES_DEF = 1024;

	// Characters held by the two key registers together
	localparam int unsigned KEY_REG_CHARS = 16;

	// Configuration register indexes
	localparam logic [1:0] REG_KEY_LOW   = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
	localparam logic [1:0] REG_KEY_LEN   = 2'd2;
	localparam logic [1:0] REG_VALUE_CAP = 2'd3;

	// Register reset values
	localparam logic [4:0]  KEY_LEN_RST   = 5'd1;
	localparam logic [10:0] VALUE_CAP_RST = 11'd256;

	// Character codes
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Most results a single body byte can produce
	localparam int unsigned MAX_PUSH = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_body;
	} body_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last;
		logic       found;
		logic       bad_escape;
	} result_t;

	// Results produced by one byte, in order, slot 0 first
	typedef struct packed {
		result_t [MAX_PUSH-1:0] item;
		logic [1:0]             count;
	} push_t;

endpackage

`default_nettype wire

FILE: rtl/core/ffd_stream_if.sv
// Valid/ready stream interface used for the body and result channels.
// Payload type is a parameter; types come from ffd_pkg.
`default_nettype none

interface ffd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ffd_window.sv
// Key search window: recent body bytes, newest first, and a parallel
// compare against the configured key. Uses ffd_pkg.
`default_nettype none

module ffd_window #(
	parameter int unsigned MAX_KEY_CHARS = ffd_pkg::MAX_KEY_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        shift,
	input  wire logic        clear,
	input  wire logic [7:0]  in_byte,
	input  wire logic [63:0] key_low,
	input  wire logic [63:0] key_high,
	input  wire logic [4:0]  key_length,
	output logic             match
);
	localparam int unsigned LEN_W = $clog2(MAX_KEY_CHARS + 1);

	logic [7:0]       recent_q [MAX_KEY_CHARS];
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] klen;
	logic [ffd_pkg::KEY_REG_CHARS-1:0][7:0] key_chars;
	logic [4:0]       ki;
	logic             all_eq;

	assign key_chars = {key_high, key_low};
	assign klen = (key_length > 5'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS)
	                                               : key_length[LEN_W-1:0];

	// recent_q[j] lines up with key character klen-1-j
	always_comb begin
		all_eq = 1'b1;
		ki     = '0;
		for (int j = 0; j < MAX_KEY_CHARS; j++) begin
			ki = 5'(klen) - 5'(j + 1);
			if ((5'(j) < 5'(klen)) && (recent_q[j] != key_chars[ki[3:0]]))
				all_eq = 1'b0;
		end
	end

	assign match = (fill_q >= klen) && all_eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int j = 0; j < MAX_KEY_CHARS; j++)
				recent_q[j] <= '0;
		end else if (clear) begin
			fill_q <= '0;
			for (int j = 0; j < MAX_KEY_CHARS; j++)
				recent_q[j] <= '0;
		end else if (shift) begin
			recent_q[0] <= in_byte;
			for (int j = 1; j < MAX_KEY_CHARS; j++)
				recent_q[j] <= recent_q[j-1];
			if (fill_q < LEN_W'(MAX_KEY_CHARS))
				fill_q <= fill_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ffd_decode.sv
// Value tracking and percent decoding: per-body state and the ordered list
// of results one byte produces. Uses ffd_pkg.
`default_nettype none

module ffd_decode #(
	parameter int unsigned MAX_VALUE_BYTES = ffd_pkg::MAX_VALUE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_body,
	input  wire logic        win_match,
	input  wire logic [10:0] value_capacity,
	output logic             matched,
	output ffd_pkg::push_t   push
);
	localparam int unsigned RAW_W = $clog2(MAX_VALUE_BYTES);

	// Escape progress
	localparam logic [1:0] PH_NONE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	logic             matched_q, closed_q, err_q;
	logic [RAW_W-1:0] raw_q;
	logic [1:0]       phase_q;
	logic [7:0]       held_q;

	logic             m_n, c_n, e_n;
	logic [RAW_W-1:0] raw_n;
	logic [1:0]       ph_n;
	logic [7:0]       hd_n;
	logic [RAW_W-1:0] limit;
	logic [10:0]      lim_w;
	logic [RAW_W:0]   raw_inc;
	logic             dv, do_close;
	logic [7:0]       db;
	logic [4:0]       hi, lo;
	logic [1:0]       n;
	ffd_pkg::result_t [ffd_pkg::MAX_PUSH-1:0] slots;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// At most capacity-1 raw bytes; zero capacity acts as one
	always_comb begin
		if (value_capacity == '0)
			lim_w = '0;
		else if (value_capacity > 11'(MAX_VALUE_BYTES))
			lim_w = 11'(MAX_VALUE_BYTES - 1);
		else
			lim_w = value_capacity - 11'd1;
	end
	assign limit   = lim_w[RAW_W-1:0];
	assign raw_inc = {1'b0, raw_q} + 1'b1;
	assign matched = matched_q;

	always_comb begin
		m_n      = matched_q;
		c_n      = closed_q;
		e_n      = err_q;
		raw_n    = raw_q;
		ph_n     = phase_q;
		hd_n     = held_q;
		dv       = 1'b0;
		db       = '0;
		do_close = 1'b0;
		hi       = hex_val(held_q);
		lo       = hex_val(in_byte);

		if (!matched_q) begin
			if (in_byte == ffd_pkg::CH_EQUALS && win_match) begin
				m_n   = 1'b1;
				raw_n = '0;
				if (limit == '0)
					c_n = 1'b1;
			end
		end else if (!closed_q) begin
			if (in_byte == ffd_pkg::CH_AMP) begin
				do_close = 1'b1;
			end else begin
				raw_n = raw_inc[RAW_W-1:0];
				unique case (phase_q)
					PH_PCT: begin
						hd_n = in_byte;
						ph_n = PH_DIGIT;
					end
					PH_DIGIT: begin
						ph_n = PH_NONE;
						dv   = 1'b1;
						if (hi[4] && lo[4]) begin
							db = {hi[3:0], lo[3:0]};
						end else begin
							e_n = 1'b1;
							db  = '0;
						end
					end
					default: begin
						if (in_byte == ffd_pkg::CH_PERCENT) begin
							ph_n = PH_PCT;
						end else begin
							dv = 1'b1;
							db = (in_byte == ffd_pkg::CH_PLUS) ? ffd_pkg::CH_SPACE
							                                   : in_byte;
						end
					end
				endcase
				if (raw_inc >= {1'b0, limit})
					do_close = 1'b1;
			end
		end

		if (end_of_body && m_n && !c_n)
			do_close = 1'b1;

		// Ordered result slots: decoded byte, cut-off escape, end marker
		slots = '0;
		n     = '0;
		if (dv) begin
			slots[n] = '{out_byte: db, has_byte: 1'b1, last: 1'b0,
			             found: 1'b1, bad_escape: e_n};
			n = n + 1'b1;
		end
		if (do_close && ph_n != PH_NONE) begin
			slots[n] = '{out_byte: ffd_pkg::CH_PERCENT, has_byte: 1'b1,
			             last: 1'b0, found: 1'b1, bad_escape: e_n};
			n = n + 1'b1;
		end
		if (do_close && ph_n == PH_DIGIT) begin
			slots[n] = '{out_byte: (hd_n == ffd_pkg::CH_PLUS) ? ffd_pkg::CH_SPACE : hd_n,
			             has_byte: 1'b1, last: 1'b0, found: 1'b1, bad_escape: e_n};
			n = n + 1'b1;
		end
		if (end_of_body) begin
			slots[n] = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1,
			             found: m_n, bad_escape: e_n};
			n = n + 1'b1;
		end
		if (do_close) begin
			c_n  = 1'b1;
			ph_n = PH_NONE;
		end

		push.item  = slots;
		push.count = advance ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= 1'b0;
			closed_q  <= 1'b0;
			err_q     <= 1'b0;
			raw_q     <= '0;
			phase_q   <= PH_NONE;
			held_q    <= '0;
		end else if (advance) begin
			if (end_of_body) begin
				matched_q <= 1'b0;
				closed_q  <= 1'b0;
				err_q     <= 1'b0;
				raw_q     <= '0;
				phase_q   <= PH_NONE;
				held_q    <= '0;
			end else begin
				matched_q <= m_n;
				closed_q  <= c_n;
				err_q     <= e_n;
				raw_q     <= raw_n;
				phase_q   <= ph_n;
				held_q    <= hd_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ffd_result_q.sv
// Four-entry result queue: takes up to three results per cycle, hands out
// one per transfer from registers. Uses ffd_pkg and ffd_stream_if.
`default_nettype none

module ffd_result_q (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  ffd_pkg::push_t push,
	output logic           room,
	ffd_stream_if.source   result
);
	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	ffd_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             pop;

	assign pop          = (cnt_q != '0) && result.ready;
	assign result.valid = (cnt_q != '0);
	assign result.data  = mem_q[rd_ptr_q];
	assign room         = cnt_q <= (PTR_W+1)'(DEPTH - ffd_pkg::MAX_PUSH);

	always_ff @(posedge clk) begin
		for (int e = 0; e < DEPTH; e++) begin
			logic [PTR_W-1:0] k;
			k = PTR_W'(e) - wr_ptr_q;
			if (3'(k) < 3'(push.count))
				mem_q[e] <= push.item[k[1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/form_field_extract_decode.sv
// Top level of the form field extractor and percent decoder.
// Depends on ffd_pkg, ffd_stream_if, ffd_window, ffd_decode, ffd_result_q.
`default_nettype none

// Form field extractor. The body channel carries a URL-encoded form body, one
// byte per transfer, with end_of_body on its final byte. The block finds the
// first spot where the configured key followed by '=' appears, then sends
// the value bytes that follow (up to '&', the end of the body, or
// value_capacity-1 raw bytes) decoded: '+' becomes a space, '%' and two hex
// digits become one byte. A non-hex escape gives out_byte 0 and sets the
// sticky bad_escape flag; an escape cut off by the end of the value comes out
// literally, but for a held '+' that becomes a space. Every body closes with
// one end marker (has_byte 0, last 1) whose found bit tells whether the key
// was seen. Rate: one body byte per cycle while the result queue has room.
// A byte enters the input register, where it is compared against the key
// window and decoded once the queue has room; its results land in a
// four-entry result queue and are offered from its registers. Most bytes give
// zero or one result; a byte that also closes an escape and the body gives up
// to three, and the body channel then pauses while the queue drains at one
// result per cycle as long as result.ready is high. Configuration writes take
// effect at the next clock edge and are meant for idle periods.

module form_field_extract_decode #(
	parameter int unsigned MAX_KEY_CHARS   = ffd_pkg::MAX_KEY_CHARS_DEF,
	parameter int unsigned MAX_VALUE_BYTES = ffd_pkg::MAX_VALUE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	ffd_stream_if.sink       body,
	ffd_stream_if.source     result
);
	// Configuration registers
	logic [63:0] key_low_q, key_high_q;
	logic [4:0]  key_len_q;
	logic [10:0] value_cap_q;

	// Input register stage
	logic            valid_s1;
	ffd_pkg::body_t  body_s1;

	logic           advance, room, win_match, matched, win_shift, win_clear;
	ffd_pkg::push_t push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q   <= '0;
			key_high_q  <= '0;
			key_len_q   <= ffd_pkg::KEY_LEN_RST;
			value_cap_q <= ffd_pkg::VALUE_CAP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ffd_pkg::REG_KEY_LOW:   key_low_q   <= cfg_data;
				ffd_pkg::REG_KEY_HIGH:  key_high_q  <= cfg_data;
				ffd_pkg::REG_KEY_LEN:   key_len_q   <= cfg_data[4:0];
				ffd_pkg::REG_VALUE_CAP: value_cap_q <= cfg_data[10:0];
			endcase
		end
	end

	// The held byte is processed once the queue can take its worst case
	assign advance    = valid_s1 && room;
	assign body.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (body.ready)
			valid_s1 <= body.valid;
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready)
			body_s1 <= body.data;
	end

	// Window only moves while searching and not on the completing '='
	assign win_shift = advance && !matched &&
	                   !(body_s1.in_byte == ffd_pkg::CH_EQUALS && win_match);
	assign win_clear = advance && body_s1.end_of_body;

	ffd_window #(
		.MAX_KEY_CHARS (MAX_KEY_CHARS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift      (win_shift),
		.clear      (win_clear),
		.in_byte    (body_s1.in_byte),
		.key_low    (key_low_q),
		.key_high   (key_high_q),
		.key_length (key_len_q),
		.match      (win_match)
	);

	ffd_decode #(
		.MAX_VALUE_BYTES (MAX_VALUE_BYTES)
	) u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.in_byte        (body_s1.in_byte),
		.end_of_body    (body_s1.end_of_body),
		.win_match      (win_match),
		.value_capacity (value_cap_q),
		.matched        (matched),
		.push           (push)
	);

	ffd_result_q u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

`default_nettype wire
